>>> sv/tpd_pkg.sv
// ----------------------------------------------------------------------------
// tpd_pkg
// Shared widths, constants and request/response types for the track point
// distance decimator.
// ----------------------------------------------------------------------------
package tpd_pkg;

    // transaction field widths
    localparam int LAT_W = 31;
    localparam int LON_W = 32;

    // configuration
    localparam int                APB_DATA_W         = 32;
    localparam int                APB_ADDR_W         = 3;
    localparam int                REG_IDX_W          = APB_ADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_MIN_DISTANCE = 1'b0;
    localparam int                CFG_W              = 20;
    localparam logic [CFG_W-1:0]  MIN_DIST_RESET     = 20'd100;

    // cosine table
    localparam int COS_W               = 17;
    localparam int COS_ENTRIES_DEFAULT = 1024;
    localparam int IDX_MAX_W           = 16;

    // 1e-7 degree in cm, Q16
    localparam int               K_W             = 17;
    localparam logic [K_W-1:0]   CM_PER_UNIT_Q16 = 17'd72955;

    // 90 degrees in 1e-7 degree units
    localparam logic [LAT_W-1:0] LAT_90_DEG = 31'd900000000;

    // shared shift-add multiplier
    localparam int MCAND_W  = 41;
    localparam int MPLIER_W = 28;
    localparam int PROD_W   = MCAND_W + MPLIER_W;

    // fixed-point scaling
    localparam int Q8_SHIFT  = 8;
    localparam int COS_SHIFT = 16;
    localparam int SQ_W      = 28;
    localparam int ACC_W     = 2 * SQ_W + 1;

    // index divider
    localparam int DIV_W = 47;

    typedef struct packed {
        logic                start;
        logic [MCAND_W-1:0]  mcand;
        logic [MPLIER_W-1:0] mplier;
    } t_mul_req;

    typedef struct packed {
        logic              done;
        logic [PROD_W-1:0] product;
    } t_mul_rsp;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
    } t_div_req;

    typedef struct packed {
        logic                 done;
        logic [IDX_MAX_W-1:0] quotient;
    } t_div_rsp;

endpackage

>>> sv/tpd_pos_if.sv
// ----------------------------------------------------------------------------
// tpd_pos_if
// Position message channel: valid/ready with has_position, latitude and
// longitude.
// ----------------------------------------------------------------------------
interface tpd_pos_if;

    logic                               valid;
    logic                               ready;
    logic                               has_position;
    logic signed [tpd_pkg::LAT_W-1:0]   latitude;
    logic signed [tpd_pkg::LON_W-1:0]   longitude;

    modport source (
        output valid, has_position, latitude, longitude,
        input  ready
    );

    modport sink (
        input  valid, has_position, latitude, longitude,
        output ready
    );

endinterface

>>> sv/tpd_kept_if.sv
// ----------------------------------------------------------------------------
// tpd_kept_if
// Kept point channel: valid/ready with kept_latitude and kept_longitude.
// ----------------------------------------------------------------------------
interface tpd_kept_if;

    logic                               valid;
    logic                               ready;
    logic signed [tpd_pkg::LAT_W-1:0]   kept_latitude;
    logic signed [tpd_pkg::LON_W-1:0]   kept_longitude;

    modport source (
        output valid, kept_latitude, kept_longitude,
        input  ready
    );

    modport sink (
        input  valid, kept_latitude, kept_longitude,
        output ready
    );

endinterface

>>> sv/tpd_cos_rom.sv
// ----------------------------------------------------------------------------
// tpd_cos_rom
// Cosine ROM over 0..90 degrees, Q16, built at elaboration; registered read.
// ----------------------------------------------------------------------------
module tpd_cos_rom #(
    parameter int COS_ENTRIES = tpd_pkg::COS_ENTRIES_DEFAULT
) (
    input  logic                           i_clk,
    input  logic [$clog2(COS_ENTRIES)-1:0] i_addr,
    output logic [tpd_pkg::COS_W-1:0]      o_data
);

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint unsigned ONE_Q30     = 64'd1 << 30;

    // Taylor series to x^20 in Q30, rounded to Q16
    function automatic logic [tpd_pkg::COS_W-1:0] cos_value(input int unsigned idx);
        longint unsigned a;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned rnd;
        longint          sum;
        a    = (64'(idx) * HALF_PI_Q30) / COS_ENTRIES;
        x2   = (a * a) >> 30;
        term = ONE_Q30;
        sum  = longint'(ONE_Q30);
        for (int k = 0; k < 10; k++) begin
            term = ((term * x2) >> 30) / 64'((2 * k + 1) * (2 * k + 2));
            if ((k % 2) == 0) begin
                sum = sum - longint'(term);
            end else begin
                sum = sum + longint'(term);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        rnd = (unsigned'(sum) + 64'd8192) >> 14;
        if (rnd > 64'd65536) begin
            rnd = 64'd65536;
        end
        return tpd_pkg::COS_W'(rnd);
    endfunction

    logic [tpd_pkg::COS_W-1:0] rom_data [COS_ENTRIES];
    logic [tpd_pkg::COS_W-1:0] r_data;

    for (genvar g = 0; g < COS_ENTRIES; g++) begin : g_rom
        assign rom_data[g] = cos_value(g);
    end

    always_ff @(posedge i_clk) begin
        r_data <= rom_data[i_addr];
    end

    assign o_data = r_data;

endmodule

>>> sv/tpd_serial_mul.sv
// ----------------------------------------------------------------------------
// tpd_serial_mul
// Shift-add multiplier: one multiplier bit per cycle, LSB first; the
// multiplier register doubles as the low half of the product.
// ----------------------------------------------------------------------------
module tpd_serial_mul (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tpd_pkg::t_mul_req i_req,
    output tpd_pkg::t_mul_rsp o_rsp
);

    localparam int CNT_W = $clog2(tpd_pkg::MPLIER_W);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(tpd_pkg::MPLIER_W - 1);

    logic                          r_busy;
    logic                          r_done;
    logic [CNT_W-1:0]              r_cnt;
    logic [tpd_pkg::MCAND_W-1:0]   r_mcand;
    logic [tpd_pkg::MCAND_W-1:0]   r_hi;
    logic [tpd_pkg::MPLIER_W-1:0]  r_lo;
    logic [tpd_pkg::MCAND_W:0]     sum;

    assign sum = {1'b0, r_hi} + (r_lo[0] ? {1'b0, r_mcand} : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == LAST);
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == LAST) begin
                    r_busy <= 1'b0;
                end
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_mcand <= i_req.mcand;
            r_hi    <= '0;
            r_lo    <= i_req.mplier;
        end else if (r_busy) begin
            r_hi <= sum[tpd_pkg::MCAND_W:1];
            r_lo <= {sum[0], r_lo[tpd_pkg::MPLIER_W-1:1]};
        end
    end

    assign o_rsp.done    = r_done;
    assign o_rsp.product = {r_hi, r_lo};

endmodule

>>> sv/tpd_idx_div.sv
// ----------------------------------------------------------------------------
// tpd_idx_div
// Restoring divider by 90 degrees: one quotient bit per cycle, giving the
// cosine table index.
// ----------------------------------------------------------------------------
module tpd_idx_div #(
    parameter int COS_ENTRIES = tpd_pkg::COS_ENTRIES_DEFAULT
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tpd_pkg::t_div_req i_req,
    output tpd_pkg::t_div_rsp o_rsp
);

    localparam int IDX_W = $clog2(COS_ENTRIES);
    localparam int CNT_W = $clog2(IDX_W);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(IDX_W - 1);
    localparam logic [tpd_pkg::DIV_W-1:0] DSH_INIT =
        tpd_pkg::DIV_W'(tpd_pkg::LAT_90_DEG) << (IDX_W - 1);

    logic                            r_busy;
    logic                            r_done;
    logic [CNT_W-1:0]                r_cnt;
    logic [tpd_pkg::DIV_W-1:0]       r_rem;
    logic [tpd_pkg::DIV_W-1:0]       r_dsh;
    logic [tpd_pkg::IDX_MAX_W-1:0]   r_q;
    logic                            ge;

    assign ge = (r_rem >= r_dsh);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == LAST);
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == LAST) begin
                    r_busy <= 1'b0;
                end
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= i_req.dividend;
            r_dsh <= DSH_INIT;
            r_q   <= '0;
        end else if (r_busy) begin
            if (ge) begin
                r_rem <= r_rem - r_dsh;
            end
            r_dsh <= r_dsh >> 1;
            r_q   <= {r_q[tpd_pkg::IDX_MAX_W-2:0], ge};
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_q;

endmodule

>>> sv/track_point_distance_decimator_top.sv
// ----------------------------------------------------------------------------
// track_point_distance_decimator_top
// Minimum-distance thinning of a position track: keeps the first position
// and then each position far enough from the last kept one.
// ----------------------------------------------------------------------------
//  port    | dir | handshake      | payload
//  i_pos   | in  | valid / ready  | has_position, latitude, longitude
//  o_kept  | out | valid / ready  | kept_latitude, kept_longitude
//  APB     | in  | psel / penable | min_distance_cm at byte address 0
//
//  A message without a position is taken and dropped; a first position goes
//  straight to the output step. Otherwise the shared shift-add multiplier (28
//  multiplier bits) forms the index product, then the index divider runs
//  (skipped at or past 90 deg), then the dy, dx, square and threshold products.
//  The squares are skipped when a coordinate difference alone decides; a
//  dropped point skips the output step. A full output register adds its wait.
//  One transaction in flight; the output register frees i_pos once loaded.
//  Synchronous active-low reset; no clearing pass.
// ----------------------------------------------------------------------------
module track_point_distance_decimator_top #(
    parameter int COS_ENTRIES = tpd_pkg::COS_ENTRIES_DEFAULT
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    tpd_pos_if.sink                           i_pos,
    tpd_kept_if.source                        o_kept,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [tpd_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [tpd_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [tpd_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready
);

    localparam int IDX_W = $clog2(COS_ENTRIES);
    localparam int LAT_W = tpd_pkg::LAT_W;
    localparam int LON_W = tpd_pkg::LON_W;

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_IDX_MUL = 4'd1;
    localparam logic [3:0] ST_IDX_DIV = 4'd2;
    localparam logic [3:0] ST_DY      = 4'd3;
    localparam logic [3:0] ST_E       = 4'd4;
    localparam logic [3:0] ST_DX      = 4'd5;
    localparam logic [3:0] ST_SQX     = 4'd6;
    localparam logic [3:0] ST_SQY     = 4'd7;
    localparam logic [3:0] ST_THR     = 4'd8;
    localparam logic [3:0] ST_EMIT    = 4'd9;

    logic [3:0]                    r_state;
    logic [3:0]                    n_state;
    logic                          r_seen;
    logic [LAT_W-1:0]              r_lat;
    logic [LON_W-1:0]              r_lon;
    logic [LAT_W-1:0]              r_last_lat;
    logic [LON_W-1:0]              r_last_lon;
    logic [IDX_W-1:0]              r_idx;
    logic [IDX_W-1:0]              n_idx;
    logic [tpd_pkg::MCAND_W-1:0]   r_dy;
    logic [tpd_pkg::ACC_W-1:0]     r_acc;
    logic [tpd_pkg::CFG_W-1:0]     r_min_dist;
    logic                          r_out_valid;
    logic [LAT_W-1:0]              r_out_lat;
    logic [LON_W-1:0]              r_out_lon;

    tpd_pkg::t_mul_req             mul_req;
    tpd_pkg::t_mul_rsp             mul_rsp;
    tpd_pkg::t_div_req             div_req;
    tpd_pkg::t_div_rsp             div_rsp;
    logic [tpd_pkg::COS_W-1:0]     cos_q16;

    logic                          pos_accept;
    logic                          emit_go;
    logic [LAT_W:0]                lat_diff;
    logic [LON_W:0]                lon_diff;
    logic [LAT_W-1:0]              dlat;
    logic [LON_W-1:0]              dlon;
    logic [LAT_W-1:0]              alat;
    logic                          lat_sat;
    logic [tpd_pkg::MCAND_W-1:0]   prod_q8;
    logic [tpd_pkg::MCAND_W-1:0]   prod_cos;
    logic [2*tpd_pkg::SQ_W-1:0]    square;
    logic [tpd_pkg::ACC_W-1:0]     thr_sq;
    logic                          far;
    logic [tpd_pkg::REG_IDX_W-1:0] reg_idx;
    logic                          cfg_write;

    // ---- configuration ----
    assign pready    = 1'b1;
    assign reg_idx   = paddr[tpd_pkg::APB_ADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite && pready
                       && (reg_idx == tpd_pkg::REG_MIN_DISTANCE);
    assign prdata    = (reg_idx == tpd_pkg::REG_MIN_DISTANCE)
                       ? tpd_pkg::APB_DATA_W'(r_min_dist) : '0;

    // ---- datapath helpers ----
    assign lat_diff = {r_lat[LAT_W-1], r_lat} - {r_last_lat[LAT_W-1], r_last_lat};
    assign lon_diff = {r_lon[LON_W-1], r_lon} - {r_last_lon[LON_W-1], r_last_lon};
    assign dlat     = lat_diff[LAT_W] ? LAT_W'(-lat_diff) : lat_diff[LAT_W-1:0];
    assign dlon     = lon_diff[LON_W] ? LON_W'(-lon_diff) : lon_diff[LON_W-1:0];
    assign alat     = r_last_lat[LAT_W-1] ? LAT_W'(-r_last_lat) : r_last_lat;
    assign lat_sat  = (alat >= tpd_pkg::LAT_90_DEG);

    assign prod_q8  = mul_rsp.product[tpd_pkg::Q8_SHIFT +: tpd_pkg::MCAND_W];
    assign prod_cos = mul_rsp.product[tpd_pkg::COS_SHIFT +: tpd_pkg::MCAND_W];
    assign square   = mul_rsp.product[2*tpd_pkg::SQ_W-1:0];
    assign thr_sq   = tpd_pkg::ACC_W'({mul_rsp.product[2*tpd_pkg::CFG_W-1:0],
                                       {(2*tpd_pkg::Q8_SHIFT){1'b0}}});
    assign far      = (|prod_cos[tpd_pkg::MCAND_W-1:tpd_pkg::SQ_W])
                      || (|r_dy[tpd_pkg::MCAND_W-1:tpd_pkg::SQ_W]);

    assign pos_accept = i_pos.valid && (r_state == ST_IDLE);
    assign emit_go    = !r_out_valid || o_kept.ready;

    // ---- sequencer ----
    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        mul_req = '0;
        div_req = '0;
        case (r_state)
            ST_IDLE: begin
                if (pos_accept && i_pos.has_position) begin
                    if (!r_seen) begin
                        n_state = ST_EMIT;
                    end else begin
                        n_state        = ST_IDX_MUL;
                        mul_req.start  = 1'b1;
                        mul_req.mcand  = tpd_pkg::MCAND_W'(alat);
                        mul_req.mplier = tpd_pkg::MPLIER_W'(COS_ENTRIES);
                    end
                end
            end
            ST_IDX_MUL: begin
                if (mul_rsp.done) begin
                    if (lat_sat) begin
                        n_idx          = IDX_W'(COS_ENTRIES - 1);
                        n_state        = ST_DY;
                        mul_req.start  = 1'b1;
                        mul_req.mcand  = tpd_pkg::MCAND_W'(dlat);
                        mul_req.mplier = tpd_pkg::MPLIER_W'(tpd_pkg::CM_PER_UNIT_Q16);
                    end else begin
                        n_state          = ST_IDX_DIV;
                        div_req.start    = 1'b1;
                        div_req.dividend = mul_rsp.product[tpd_pkg::DIV_W-1:0];
                    end
                end
            end
            ST_IDX_DIV: begin
                if (div_rsp.done) begin
                    n_idx          = div_rsp.quotient[IDX_W-1:0];
                    n_state        = ST_DY;
                    mul_req.start  = 1'b1;
                    mul_req.mcand  = tpd_pkg::MCAND_W'(dlat);
                    mul_req.mplier = tpd_pkg::MPLIER_W'(tpd_pkg::CM_PER_UNIT_Q16);
                end
            end
            ST_DY: begin
                if (mul_rsp.done) begin
                    n_state        = ST_E;
                    mul_req.start  = 1'b1;
                    mul_req.mcand  = tpd_pkg::MCAND_W'(dlon);
                    mul_req.mplier = tpd_pkg::MPLIER_W'(tpd_pkg::CM_PER_UNIT_Q16);
                end
            end
            ST_E: begin
                if (mul_rsp.done) begin
                    n_state        = ST_DX;
                    mul_req.start  = 1'b1;
                    mul_req.mcand  = prod_q8;
                    mul_req.mplier = tpd_pkg::MPLIER_W'(cos_q16);
                end
            end
            ST_DX: begin
                if (mul_rsp.done) begin
                    if (far) begin
                        n_state = ST_EMIT;
                    end else begin
                        n_state        = ST_SQX;
                        mul_req.start  = 1'b1;
                        mul_req.mcand  = prod_cos;
                        mul_req.mplier = prod_cos[tpd_pkg::SQ_W-1:0];
                    end
                end
            end
            ST_SQX: begin
                if (mul_rsp.done) begin
                    n_state        = ST_SQY;
                    mul_req.start  = 1'b1;
                    mul_req.mcand  = r_dy;
                    mul_req.mplier = r_dy[tpd_pkg::SQ_W-1:0];
                end
            end
            ST_SQY: begin
                if (mul_rsp.done) begin
                    n_state        = ST_THR;
                    mul_req.start  = 1'b1;
                    mul_req.mcand  = tpd_pkg::MCAND_W'(r_min_dist);
                    mul_req.mplier = tpd_pkg::MPLIER_W'(r_min_dist);
                end
            end
            ST_THR: begin
                if (mul_rsp.done) begin
                    n_state = (r_acc >= thr_sq) ? ST_EMIT : ST_IDLE;
                end
            end
            ST_EMIT: begin
                if (emit_go) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // ---- control registers ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_seen      <= 1'b0;
            r_out_valid <= 1'b0;
            r_last_lat  <= '0;
            r_last_lon  <= '0;
            r_min_dist  <= tpd_pkg::MIN_DIST_RESET;
        end else begin
            r_state <= n_state;
            if (cfg_write) begin
                r_min_dist <= pwdata[tpd_pkg::CFG_W-1:0];
            end
            if ((r_state == ST_EMIT) && emit_go) begin
                r_out_valid <= 1'b1;
                r_seen      <= 1'b1;
                r_last_lat  <= r_lat;
                r_last_lon  <= r_lon;
            end else if (o_kept.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ---- payload registers ----
    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        if (pos_accept) begin
            r_lat <= i_pos.latitude;
            r_lon <= i_pos.longitude;
        end
        if ((r_state == ST_DY) && mul_rsp.done) begin
            r_dy <= prod_q8;
        end
        if ((r_state == ST_SQX) && mul_rsp.done) begin
            r_acc <= tpd_pkg::ACC_W'(square);
        end else if ((r_state == ST_SQY) && mul_rsp.done) begin
            r_acc <= r_acc + tpd_pkg::ACC_W'(square);
        end
        if ((r_state == ST_EMIT) && emit_go) begin
            r_out_lat <= r_lat;
            r_out_lon <= r_lon;
        end
    end

    assign i_pos.ready           = (r_state == ST_IDLE);
    assign o_kept.valid          = r_out_valid;
    assign o_kept.kept_latitude  = r_out_lat;
    assign o_kept.kept_longitude = r_out_lon;

    // ---- shared units ----
    tpd_serial_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_rsp   (mul_rsp)
    );

    tpd_idx_div #(
        .COS_ENTRIES (COS_ENTRIES)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    tpd_cos_rom #(
        .COS_ENTRIES (COS_ENTRIES)
    ) u_rom (
        .i_clk  (i_clk),
        .i_addr (r_idx),
        .o_data (cos_q16)
    );

    // ---- assertions ----
    a_mul_done_in_mul_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_rsp.done |-> (r_state == ST_IDX_MUL || r_state == ST_DY || r_state == ST_E
                          || r_state == ST_DX || r_state == ST_SQX || r_state == ST_SQY
                          || r_state == ST_THR))
        else $error("multiplier result outside a multiply step");

    a_div_done_in_div_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == ST_IDX_DIV))
        else $error("divider result outside the index step");

    a_no_maths_before_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_seen |-> (r_state == ST_IDLE || r_state == ST_EMIT))
        else $error("distance computed before any point was kept");

    a_emit_loads_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_EMIT) && emit_go) |=> (r_seen && r_out_valid && r_state == ST_IDLE))
        else $error("kept point not loaded into the output register");

endmodule
